[hdl/bpa_pkg.sv]
package bpa_pkg;

    localparam int GRANT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 2'd2;

    typedef struct packed {
        logic [GRANT_W-1:0]  granted_slot;
        logic                stolen;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

[hdl/bpa_list_core.sv]
module bpa_list_core #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_func,
    input  logic [bpa_pkg::INDEX_W-1:0] i_slot_index,
    output bpa_pkg::t_result            o_result
);

    // link values run 0..SLOT_COUNT, SLOT_COUNT being null
    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);

    typedef logic [LW-1:0] t_link;

    t_link r_next [SLOT_COUNT];
    t_link r_prev [SLOT_COUNT];
    logic  r_use  [SLOT_COUNT];
    t_link r_free_head, r_free_tail, r_used_head, r_used_tail;

    t_link n_next [SLOT_COUNT];
    t_link n_prev [SLOT_COUNT];
    logic  n_use  [SLOT_COUNT];
    t_link n_free_head, n_free_tail, n_used_head, n_used_tail;

    function automatic logic is_slot(input t_link x);
        return x < NIL;
    endfunction

    always_comb begin
        t_link s;
        t_link p;
        t_link n;
        t_link h;
        t_link t;
        logic  rem_free;
        logic  app_used;
        logic  go;
        logic  idx_ok;

        n_next      = r_next;
        n_prev      = r_prev;
        n_use       = r_use;
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        n_used_head = r_used_head;
        n_used_tail = r_used_tail;
        o_result    = '0;
        p           = NIL;
        n           = NIL;
        h           = NIL;
        t           = NIL;

        idx_ok = {1'b0, i_slot_index} < (bpa_pkg::INDEX_W + 1)'(SLOT_COUNT);

        // pick the slot, the list it leaves and the list it joins
        if (i_func == bpa_pkg::FUNC_ALLOC) begin
            rem_free = is_slot(r_free_tail);
            s        = rem_free ? r_free_tail : r_used_head;
            app_used = 1'b1;
            go       = is_slot(s);
            o_result.stolen = !rem_free;
            if (go) begin
                o_result.granted_slot = bpa_pkg::GRANT_W'(s);
            end
        end else begin
            rem_free = 1'b0;
            s        = idx_ok ? LW'(i_slot_index) : NIL;
            app_used = 1'b0;
            go       = 1'b0;
            if (!idx_ok) begin
                o_result.status = bpa_pkg::STATUS_RANGE;
            end else if (!r_use[s[IW-1:0]]) begin
                o_result.status = bpa_pkg::STATUS_DOUBLE;
            end else begin
                go = 1'b1;
            end
        end

        if (go) begin
            // unlink from the source list
            h = rem_free ? r_free_head : r_used_head;
            t = rem_free ? r_free_tail : r_used_tail;
            p = r_prev[s[IW-1:0]];
            n = r_next[s[IW-1:0]];
            if (is_slot(p)) begin
                n_next[p[IW-1:0]] = n;
            end else begin
                h = is_slot(n) ? n : NIL;
            end
            if (is_slot(n)) begin
                n_prev[n[IW-1:0]] = p;
            end else begin
                t = is_slot(p) ? p : NIL;
            end
            n_prev[s[IW-1:0]] = NIL;
            n_next[s[IW-1:0]] = NIL;
            if (rem_free) begin
                n_free_head = h;
                n_free_tail = t;
            end else begin
                n_used_head = h;
                n_used_tail = t;
            end

            // append to the tail of the destination list
            h = app_used ? n_used_head : n_free_head;
            t = app_used ? n_used_tail : n_free_tail;
            n_prev[s[IW-1:0]] = t;
            n_next[s[IW-1:0]] = NIL;
            if (is_slot(t)) begin
                n_next[t[IW-1:0]] = s;
            end else begin
                h = s;
            end
            t = s;
            if (app_used) begin
                n_used_head = h;
                n_used_tail = t;
            end else begin
                n_free_head = h;
                n_free_tail = t;
            end
            n_use[s[IW-1:0]] = app_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_next[i] <= LW'(i + 1);
                r_prev[i] <= (i == 0) ? NIL : LW'(i - 1);
                r_use[i]  <= 1'b0;
            end
            r_free_head <= '0;
            r_free_tail <= LW'(SLOT_COUNT - 1);
            r_used_head <= NIL;
            r_used_tail <= NIL;
        end else if (i_en) begin
            r_next      <= n_next;
            r_prev      <= n_prev;
            r_use       <= n_use;
            r_free_head <= n_free_head;
            r_free_tail <= n_free_tail;
            r_used_head <= n_used_head;
            r_used_tail <= n_used_tail;
        end
    end

endmodule

[hdl/buffer_pool_allocator_lru_steal.sv]
// Buffer slot pool with oldest-slot stealing. One request (allocate or
// free) can be accepted on every clock while o_stall is low, and its
// result is registered in the output register, or in the skid entry while
// the output waits. The link update is combinational: the prev/next link
// registers, the in-use bits and the four list pointers are all rewritten
// at once. Allocate hands out the most recently freed slot, or, with no free
// slot, the oldest allocated one with o_stolen set. A two-entry output buffer
// lets a request be taken while the previous result is still waiting;
// o_stall rises only when both entries hold results.
module buffer_pool_allocator_lru_steal #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic [bpa_pkg::INDEX_W-1:0]  i_slot_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bpa_pkg::GRANT_W-1:0]  o_granted_slot,
    output logic                         o_stolen,
    output logic [bpa_pkg::STATUS_W-1:0] o_status
);

    bpa_pkg::t_result w_result;
    bpa_pkg::t_result r_out;
    bpa_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             w_accept;
    logic             w_take;

    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_stall;

    bpa_list_core #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_func      (i_func),
        .i_slot_index(i_slot_index),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            // refill the output from the skid entry first
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
                if (w_accept) begin
                    r_out <= w_result;
                end
            end
        end else if (w_accept) begin
            // hold the new item beside the waiting one
            r_skid       <= w_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_granted_slot = r_out.granted_slot;
    assign o_stolen       = r_out.stolen;
    assign o_status       = r_out.status;

endmodule
